// ===== src/vertex_dedup_index_table_assert.svh =====
// Assertion macros for the vertex dedup index table
`ifndef VERTEX_DEDUP_INDEX_TABLE_ASSERT_SVH
`define VERTEX_DEDUP_INDEX_TABLE_ASSERT_SVH

// Condition holds at every clock edge outside reset
`define VDIT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Trigger implies a consequence on the next edge
`define VDIT_NEXT(label, trig, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/vdit_pkg.sv =====
package vdit_pkg;
	localparam int unsigned TableDepth = 1024;
	localparam int unsigned AddrW = $clog2(TableDepth);
	localparam int unsigned CountW = AddrW + 1;
	localparam int unsigned IdxW = 10;
	localparam int unsigned NumComp = 8;
	localparam int unsigned EntryW = NumComp * 32;

	typedef logic [EntryW-1:0] entry_t;

	// controller to datapath commands
	typedef struct packed {
		logic load;      // capture request, restart count if restart set
		logic rd;        // read entry at scan address
		logic scan_clr;  // scan address to zero
		logic scan_inc;  // next scan address
		logic append;    // write request at count
		logic done;      // strobe a result
		logic res_new;
		logic res_full;
	} ctrl_t;

	// datapath status back to controller
	typedef struct packed {
		logic hit;        // registered compare of entry just read
		logic scan_last;  // scan address is last valid entry
		logic empty;      // no entries
		logic full;       // count at depth
	} stat_t;

	// float equality on bit patterns
	function automatic logic feq(input logic [31:0] a, input logic [31:0] b);
		logic na;
		logic nb;
		na = (a[30:0] > 31'h7F800000);
		nb = (b[30:0] > 31'h7F800000);
		if (na || nb) return 1'b0;
		if ((a[30:0] | b[30:0]) == 31'd0) return 1'b1;
		return a == b;
	endfunction
endpackage

// ===== src/vdit_ctrl.sv =====
module vdit_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  vdit_pkg::stat_t st,
	output logic          busy,
	output vdit_pkg::ctrl_t cmd
);
	import vdit_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_CHK  = 3'd1;
	localparam logic [2:0] S_RD   = 3'd2;
	localparam logic [2:0] S_CMP  = 3'd3;
	localparam logic [2:0] S_EVAL = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					cmd.scan_clr = 1'b1;
					state_d = S_CHK;
				end
			end
			S_CHK: begin
				if (st.empty) begin
					cmd.append = 1'b1;
					cmd.done = 1'b1;
					cmd.res_new = 1'b1;
					state_d = S_IDLE;
				end else begin
					cmd.rd = 1'b1;
					state_d = S_RD;
				end
			end
			S_RD: state_d = S_CMP;
			S_CMP: state_d = S_EVAL;
			S_EVAL: begin
				if (st.hit) begin
					cmd.done = 1'b1;
					state_d = S_IDLE;
				end else if (st.scan_last) begin
					cmd.done = 1'b1;
					if (st.full) begin
						cmd.res_full = 1'b1;
					end else begin
						cmd.append = 1'b1;
						cmd.res_new = 1'b1;
					end
					state_d = S_IDLE;
				end else begin
					cmd.scan_inc = 1'b1;
					cmd.rd = 1'b1;
					state_d = S_RD;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	assign busy = (state_q != S_IDLE);
endmodule

// ===== src/vdit_dp.sv =====
module vdit_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  vdit_pkg::ctrl_t             cmd,
	input  logic                        uv_mode,
	input  logic                        restart,
	input  logic [vdit_pkg::EntryW-1:0] req_in,
	output vdit_pkg::stat_t             st,
	output logic                        done,
	output logic [vdit_pkg::IdxW-1:0]   vertex_index,
	output logic                        is_new,
	output logic                        table_full
);
	import vdit_pkg::*;

	entry_t             mem [TableDepth];
	entry_t             req_q;
	entry_t             rd_q;
	logic [CountW-1:0]  count_q;
	logic [AddrW-1:0]   scan_q;
	logic               hit_q;
	logic               cmp;
	logic               done_q;
	logic [IdxW-1:0]    idx_q;
	logic               new_q;
	logic               full_q;
	logic [CountW-1:0]  scan_ext;

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.load) req_q <= req_in;
	end

	// entry store: one write, one registered read
	always_ff @(posedge clk) begin
		if (cmd.append) mem[count_q[AddrW-1:0]] <= req_q;
		if (cmd.rd) rd_q <= mem[cmd.scan_inc ? scan_q + 1'b1 : scan_q];
	end

	// entry compare (position, normal; texture in uv_mode), registered
	always_comb begin
		cmp = 1'b1;
		for (int k = 0; k < 6; k++)
			cmp &= feq(rd_q[k*32 +: 32], req_q[k*32 +: 32]);
		if (uv_mode)
			for (int k = 6; k < NumComp; k++)
				cmp &= feq(rd_q[k*32 +: 32], req_q[k*32 +: 32]);
	end

	always_ff @(posedge clk) hit_q <= cmp;

	// count and scan address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			scan_q <= '0;
		end else begin
			if (cmd.load && restart) count_q <= '0;
			else if (cmd.append) count_q <= count_q + 1'b1;
			if (cmd.scan_clr) scan_q <= '0;
			else if (cmd.scan_inc) scan_q <= scan_q + 1'b1;
		end
	end

	assign scan_ext = {1'b0, scan_q};
	assign st.hit = hit_q;
	assign st.scan_last = (scan_ext + 1'b1 == count_q);
	assign st.empty = (count_q == '0);
	assign st.full = (count_q == CountW'(TableDepth));

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_q <= 1'b0;
		else done_q <= cmd.done;
	end

	always_ff @(posedge clk) begin
		if (cmd.done) begin
			new_q <= cmd.res_new;
			full_q <= cmd.res_full;
			if (cmd.res_full) idx_q <= '0;
			else if (cmd.res_new) idx_q <= IdxW'(count_q);
			else idx_q <= IdxW'(scan_q);
		end
	end

	assign done = done_q;
	assign vertex_index = idx_q;
	assign is_new = new_q;
	assign table_full = full_q;
endmodule

// ===== src/vertex_dedup_index_table.sv =====
// Vertex dedup index table: linear search over stored unique vertices.
// Stored entries are scanned in order (up to 1024), with one registered RAM read
// and a registered compare per entry; an empty table appends without a scan.
// Throughput: one corner at a time; busy stays high until the result strobe.
// Reset (arst_n low) empties the table, clears uv_mode and idles the controller.
// The result strobe lasts one cycle; the receiver cannot stall.
module vertex_dedup_index_table (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data,
	input  logic        start,
	output logic        busy,
	input  logic        restart,
	input  logic [31:0] pos_x,
	input  logic [31:0] pos_y,
	input  logic [31:0] pos_z,
	input  logic [31:0] norm_x,
	input  logic [31:0] norm_y,
	input  logic [31:0] norm_z,
	input  logic [31:0] tex_u,
	input  logic [31:0] tex_v,
	output logic        done,
	output logic [9:0]  vertex_index,
	output logic        is_new,
	output logic        table_full
);
	import vdit_pkg::*;
	`include "vertex_dedup_index_table_assert.svh"

	ctrl_t cmd;
	stat_t st;
	logic  uv_mode_q;

	// configuration register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) uv_mode_q <= 1'b0;
		else if (cfg_valid) uv_mode_q <= cfg_data;
	end

	vdit_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .st(st), .busy(busy), .cmd(cmd)
	);

	vdit_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .uv_mode(uv_mode_q), .restart(restart),
		.req_in({tex_v, tex_u, norm_z, norm_y, norm_x, pos_z, pos_y, pos_x}),
		.st(st), .done(done), .vertex_index(vertex_index), .is_new(is_new),
		.table_full(table_full)
	);

	`VDIT_ALWAYS(a_flags_excl, !(done && is_new && table_full), "new and full together")
	`VDIT_NEXT(a_done_ends_busy, cmd.done, !busy, "busy after result")
	`VDIT_NEXT(a_start_busy, start && !busy, busy, "request not taken")
	`VDIT_ALWAYS(a_append_room, !(cmd.append && st.full), "append into full table")
endmodule
